// ===== src/lcdt_pkg.sv =====
// Package for the LCD mode timing sequencer: mode codes, line timing
// constants, register indexes and parameter defaults. No dependencies.
package lcdt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  localparam int CountW = 10;
  localparam logic [CountW-1:0] ScanEnd  = CountW'(80);
  localparam logic [CountW-1:0] DrawEnd  = CountW'(80 + 172);
  localparam logic [CountW-1:0] LineLen  = CountW'(80 + 172 + 204);
  localparam logic [CountW-1:0] CountMax = '1;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_LCD_ON       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LINE_COMPARE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STAT_ENABLES = 2'd2;

  // Bits of the status interrupt enable register.
  localparam int EnHblank  = 0;
  localparam int EnVblank  = 1;
  localparam int EnScan    = 2;
  localparam int EnCompare = 3;

  localparam int DefVisibleLines = 144;
  localparam int DefTotalLines   = 154;

endpackage

// ===== src/lcd_mode_timing_sequencer.sv =====
// LCD mode timing sequencer: line cycle counter, mode sequencing and interrupt requests.
// Depends on lcdt_pkg.
// A result is registered: it is valid in the cycle after its input transaction is accepted.
// Throughput: one item per clock while the result is taken; the step is one add, a few compares
// and a mode select, and the result register frees in the cycle it is taken, so input runs back to back.
// Reset (rst, synchronous): state and configuration cleared, h-blank, line 0, no result.
module lcd_mode_timing_sequencer
  import lcdt_pkg::*;
#(
  parameter int VISIBLE_LINES = DefVisibleLines,
  parameter int TOTAL_LINES   = DefTotalLines
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  // Input stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] elapsed_cycles
  // Result stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata    // [7:0] current_line, [9:8] current_mode,
                                        // [10] coincidence, [11] oam_locked,
                                        // [12] vblank_request, [13] stat_request,
                                        // [14] sprite_scan_event, [15] line_render_event
);

  // Configuration registers.
  logic       lcd_on;
  logic [7:0] line_compare;
  logic [3:0] stat_irq_enables;

  // Timing state.
  logic [CountW-1:0] line_cycle_count, line_cycle_count_next;
  mode_t             mode_state, mode_state_next;
  logic [7:0]        line_number, line_number_next;
  logic              vblank_done, vblank_done_next;
  logic              compare_flag, compare_flag_next;

  // Result register.
  logic        res_valid;
  logic [15:0] res_data;

  logic              in_accept;
  logic [CountW:0]   count_sum;
  logic [CountW-1:0] count_sat;
  logic [8:0]        line_inc;
  logic [7:0]        line_adv;
  logic              scan_done, draw_done, line_done, enter_vblank, frame_wrap, start_scan;
  logic              cmp_hit;
  logic              vreq, sreq, scan_ev, render_ev;
  logic              oam_lock_next;

  assign s_tready  = !res_valid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign m_tvalid  = res_valid;
  assign m_tdata   = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_on           <= 1'b0;
      line_compare     <= '0;
      stat_irq_enables <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LCD_ON:       lcd_on           <= cfg_data[0];
        REG_LINE_COMPARE: line_compare     <= cfg_data;
        REG_STAT_ENABLES: stat_irq_enables <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Counter update with saturation at the counter's full scale.
  assign count_sum = {1'b0, line_cycle_count} + (CountW + 1)'(s_tdata);
  assign count_sat = count_sum[CountW] ? CountMax : count_sum[CountW-1:0];

  assign line_inc = {1'b0, line_number} + 9'd1;
  assign line_adv = (line_inc >= 9'(TOTAL_LINES)) ? 8'd0 : line_inc[7:0];

  assign scan_done    = (mode_state == MODE_SCAN) && (count_sat >= ScanEnd);
  assign draw_done    = (mode_state == MODE_DRAW) && (count_sat >= DrawEnd);
  assign line_done    = ((mode_state == MODE_HBLANK) || (mode_state == MODE_VBLANK))
                        && (count_sat >= LineLen);
  assign enter_vblank = (mode_state == MODE_HBLANK) && line_done
                        && (line_adv == 8'(VISIBLE_LINES));
  assign frame_wrap   = (mode_state == MODE_VBLANK) && line_done && (line_adv == 8'd0);
  assign start_scan   = ((mode_state == MODE_HBLANK) && line_done && !enter_vblank)
                        || frame_wrap;

  // Next state.
  always_comb begin
    line_cycle_count_next = line_cycle_count;
    mode_state_next       = mode_state;
    line_number_next      = line_number;
    vblank_done_next      = vblank_done;
    compare_flag_next     = compare_flag;
    if (!lcd_on) begin
      line_cycle_count_next = '0;
      mode_state_next       = MODE_HBLANK;
      line_number_next      = '0;
      vblank_done_next      = 1'b0;
    end else begin
      line_cycle_count_next = line_done ? (count_sat - LineLen) : count_sat;
      line_number_next      = line_done ? line_adv : line_number;
      case (mode_state)
        MODE_SCAN:   if (scan_done) mode_state_next = MODE_DRAW;
        MODE_DRAW:   if (draw_done) mode_state_next = MODE_HBLANK;
        MODE_HBLANK: begin
          if (enter_vblank) begin
            mode_state_next  = MODE_VBLANK;
            vblank_done_next = 1'b1;
          end else if (line_done) begin
            mode_state_next = MODE_SCAN;
          end
        end
        MODE_VBLANK: begin
          if (frame_wrap) begin
            mode_state_next  = MODE_SCAN;
            vblank_done_next = 1'b0;
          end
        end
        default: mode_state_next = MODE_HBLANK;
      endcase
      compare_flag_next = (line_number_next == line_compare);
    end
  end

  assign cmp_hit = (line_number_next == line_compare);

  // Requests and events of this step.
  always_comb begin
    vreq      = 1'b0;
    sreq      = 1'b0;
    scan_ev   = 1'b0;
    render_ev = 1'b0;
    if (lcd_on) begin
      vreq      = enter_vblank && !vblank_done;
      scan_ev   = scan_done;
      render_ev = draw_done;
      sreq      = (draw_done && stat_irq_enables[EnHblank])
                  || (enter_vblank && stat_irq_enables[EnVblank])
                  || (start_scan && stat_irq_enables[EnScan])
                  || (cmp_hit && stat_irq_enables[EnCompare]);
    end
  end

  assign oam_lock_next = (mode_state_next == MODE_SCAN) || (mode_state_next == MODE_DRAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cycle_count <= '0;
      mode_state       <= MODE_HBLANK;
      line_number      <= '0;
      vblank_done      <= 1'b0;
      compare_flag     <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (in_accept) begin
        line_cycle_count <= line_cycle_count_next;
        mode_state       <= mode_state_next;
        line_number      <= line_number_next;
        vblank_done      <= vblank_done_next;
        compare_flag     <= compare_flag_next;
        res_valid        <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_data <= {render_ev, scan_ev, sreq, vreq, oam_lock_next, compare_flag_next,
                   mode_state_next, line_number_next};
    end
  end

`ifndef SYNTH
  // The OAM lock bit of a result follows the mode it reports.
  a_oam_lock_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data[11] == ((res_data[9:8] == MODE_SCAN)
                                  || (res_data[9:8] == MODE_DRAW))))
    else $error("oam_locked disagrees with reported mode");

  // A v-blank request is only raised on the step that enters v-blank.
  a_vreq_in_vblank: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data[12]) |-> (res_data[9:8] == MODE_VBLANK))
    else $error("vblank request outside v-blank");

  // With the display off an accepted item leaves the timing at line zero h-blank.
  a_lcd_off_hold: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !lcd_on) |=> (line_number == 8'd0) && (mode_state == MODE_HBLANK)
                               && (line_cycle_count == '0))
    else $error("timing not held while display is off");

  // The line number stays within the frame.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, line_number} < 9'(TOTAL_LINES)))
    else $error("line number beyond frame length");
`endif

endmodule
